/* hdl/assert_macros.svh */
// Assertion macros shared by the convexity checker RTL.
// Included by files that carry concurrent checks; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/pcc_pkg.sv */
// Package for the polygon convexity checker: shared types and constants.
// No dependencies.
package pcc_pkg;

    localparam int COORD_WIDTH_DEFAULT = 16;
    localparam int OUT_TDATA_WIDTH     = 8;

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_SAT  = 2'd3;

    typedef struct packed {
        logic cw;
        logic ccw;
    } turn_t;

    typedef struct packed {
        logic too_few;
        logic convex;
    } result_t;

endpackage

/* hdl/pcc_turn.sv */
// Exact cross-product sign of (b-a) x (c-a) for one vertex triple.
// Depends on pcc_pkg.
module pcc_turn #(
    parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    output pcc_pkg::turn_t                turn
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int SW = PW + 1;

    logic signed [DW-1:0] dbx, dby, dcx, dcy;
    logic signed [PW-1:0] p, q;
    logic signed [SW-1:0] s;

    assign dbx = {bx[COORD_WIDTH-1], bx} - {ax[COORD_WIDTH-1], ax};
    assign dby = {by[COORD_WIDTH-1], by} - {ay[COORD_WIDTH-1], ay};
    assign dcx = {cx[COORD_WIDTH-1], cx} - {ax[COORD_WIDTH-1], ax};
    assign dcy = {cy[COORD_WIDTH-1], cy} - {ay[COORD_WIDTH-1], ay};

    assign p = {{(PW-DW){dbx[DW-1]}}, dbx} * {{(PW-DW){dcy[DW-1]}}, dcy};
    assign q = {{(PW-DW){dcx[DW-1]}}, dcx} * {{(PW-DW){dby[DW-1]}}, dby};
    assign s = {p[PW-1], p} - {q[PW-1], q};

    assign turn.cw  = s[SW-1];
    assign turn.ccw = !s[SW-1] && (s != '0);

endmodule

/* hdl/pcc_core.sv */
// Polygon state (kept vertices, count, turn flags) and the three turn units.
// Depends on pcc_pkg, pcc_turn and assert_macros.svh.
`include "assert_macros.svh"
module pcc_core #(
    parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic signed [COORD_WIDTH-1:0] vx,
    input  logic signed [COORD_WIDTH-1:0] vy,
    input  logic                          last,
    output pcc_pkg::result_t              result
);

    logic signed [COORD_WIDTH-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_WIDTH-1:0] second_x_reg, second_y_reg;
    logic signed [COORD_WIDTH-1:0] older_x_reg, older_y_reg;
    logic signed [COORD_WIDTH-1:0] newest_x_reg, newest_y_reg;
    logic [1:0] seen_reg, seen_next;
    logic       cw_reg, cw_next;
    logic       ccw_reg, ccw_next;

    pcc_pkg::turn_t t_run, t_close, t_wrap;
    logic have_two;
    logic cw_cur, ccw_cur, cw_all, ccw_all;

    // running triple, then the two closing triples of the polygon
    pcc_turn #(.COORD_WIDTH(COORD_WIDTH)) u_turn_run (
        .ax(older_x_reg), .ay(older_y_reg), .bx(newest_x_reg), .by(newest_y_reg),
        .cx(vx), .cy(vy), .turn(t_run)
    );
    pcc_turn #(.COORD_WIDTH(COORD_WIDTH)) u_turn_close (
        .ax(newest_x_reg), .ay(newest_y_reg), .bx(vx), .by(vy),
        .cx(first_x_reg), .cy(first_y_reg), .turn(t_close)
    );
    pcc_turn #(.COORD_WIDTH(COORD_WIDTH)) u_turn_wrap (
        .ax(vx), .ay(vy), .bx(first_x_reg), .by(first_y_reg),
        .cx(second_x_reg), .cy(second_y_reg), .turn(t_wrap)
    );

    always_comb
    begin
        have_two = seen_reg[1];
        cw_cur   = cw_reg  || (have_two && t_run.cw);
        ccw_cur  = ccw_reg || (have_two && t_run.ccw);
        cw_all   = cw_cur  || t_close.cw  || t_wrap.cw;
        ccw_all  = ccw_cur || t_close.ccw || t_wrap.ccw;

        result.too_few = !have_two;
        result.convex  = have_two && !(cw_all && ccw_all);

        if (last)
        begin
            seen_next = pcc_pkg::SEEN_NONE;
            cw_next   = 1'b0;
            ccw_next  = 1'b0;
        end
        else
        begin
            seen_next = (seen_reg == pcc_pkg::SEEN_SAT) ? seen_reg : seen_reg + 2'd1;
            cw_next   = cw_cur;
            ccw_next  = ccw_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= pcc_pkg::SEEN_NONE;
            cw_reg   <= 1'b0;
            ccw_reg  <= 1'b0;
        end
        else if (step)
        begin
            seen_reg <= seen_next;
            cw_reg   <= cw_next;
            ccw_reg  <= ccw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (seen_reg == pcc_pkg::SEEN_NONE)
            begin
                first_x_reg <= vx;
                first_y_reg <= vy;
            end
            if (seen_reg == pcc_pkg::SEEN_ONE)
            begin
                second_x_reg <= vx;
                second_y_reg <= vy;
            end
            older_x_reg  <= newest_x_reg;
            older_y_reg  <= newest_y_reg;
            newest_x_reg <= vx;
            newest_y_reg <= vy;
        end
    end

    `ASSERT_NEXT(a_clear_after_last, clk, rst_n, step && last, seen_reg == pcc_pkg::SEEN_NONE && !cw_reg && !ccw_reg)
    `ASSERT_IMPL(a_flags_need_triple, clk, rst_n, cw_reg || ccw_reg, seen_reg == pcc_pkg::SEEN_SAT)

endmodule

/* hdl/polygon_convexity_check.sv */
// Polygon convexity checker. Takes one vertex word per cycle, with tlast on the final
// vertex of each polygon, and gives one result word per polygon. While a vertex sits in the
// input register, three cross-product units (two multipliers each) judge its triples in
// parallel, so words flow back to back. The result for the last vertex in the input register
// goes to the result register. The input stalls only while a last vertex meets an earlier
// result word that the sink has not yet taken.
// Depends on pcc_pkg, pcc_core and assert_macros.svh.
`include "assert_macros.svh"
module polygon_convexity_check #(
    parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // vertex_x, vertex_y, zero fill to whole bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // convex, too_few, zero fill
    output logic [pcc_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

    logic                          in_valid_reg;
    logic signed [COORD_WIDTH-1:0] in_x_reg, in_y_reg;
    logic                          in_last_reg;
    logic                          out_valid_reg, out_valid_next;
    pcc_pkg::result_t              out_res_reg;
    pcc_pkg::result_t              core_res;
    logic                          proc;

    assign proc = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;

    pcc_core #(.COORD_WIDTH(COORD_WIDTH)) u_core (
        .clk(clk), .rst_n(rst_n), .step(proc),
        .vx(in_x_reg), .vy(in_y_reg), .last(in_last_reg), .result(core_res)
    );

    always_comb
    begin
        if (proc && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_x_reg    <= s_axis_tdata[COORD_WIDTH-1:0];
            in_y_reg    <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
            in_last_reg <= s_axis_tlast;
        end
        if (proc && in_last_reg)
            out_res_reg <= core_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(pcc_pkg::OUT_TDATA_WIDTH-2){1'b0}},
                            out_res_reg.too_few, out_res_reg.convex};

    `ASSERT_IMPL(a_result_exclusive, clk, rst_n, out_valid_reg, out_res_reg.convex != out_res_reg.too_few || !out_res_reg.convex)
    `ASSERT_NEXT(a_last_gives_result, clk, rst_n, proc && in_last_reg, out_valid_reg)
    `ASSERT_IMPL(a_result_from_last, clk, rst_n, $rose(out_valid_reg), $past(proc && in_last_reg))

endmodule
